// ----- rtl/core/rsi_pkg.sv -----
// rsi_pkg: shared widths, register indexes, transaction structs and helpers
// for the ray/sphere intersector. No dependencies.
`default_nettype none
package rsi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int MAT_W       = 16;
  localparam int IDX_W       = 3;
  localparam int RADW        = COORD_WIDTH - 1;

  localparam logic [IDX_W-1:0] REG_CENTER_X = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_CENTER_Y = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_CENTER_Z = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_RADIUS   = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_MATERIAL = IDX_W'(4);

  // datapath widths
  localparam int OCW      = COORD_WIDTH + 1;
  localparam int AW       = 2 * COORD_WIDTH;
  localparam int HW       = 2 * COORD_WIDTH + 3;
  localparam int SPL      = COORD_WIDTH + 2;
  localparam int HHW      = HW - SPL;
  localparam int AHW      = AW - SPL;
  localparam int DSW      = 4 * COORD_WIDTH + 6;
  localparam int DW       = 4 * COORD_WIDTH + 4;
  localparam int SQ_STEPS = DW / 2;
  localparam int SQW      = DW / 2;
  localparam int NW       = HW + 1;
  localparam int TRW      = AW + COORD_WIDTH;
  localparam int TW       = COORD_WIDTH + 1;
  localparam int PW       = 2 * COORD_WIDTH - FRAC_BITS + 1;
  localparam int NRW      = 2 * COORD_WIDTH - 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [RADW-1:0] RADIUS_RESET = RADW'(1) << FRAC_BITS;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t t_lower;
    coord_t t_upper;
  } ray_t;

  typedef struct packed {
    logic             hit;
    coord_t           hit_t;
    coord_t           point_x;
    coord_t           point_y;
    coord_t           point_z;
    coord_t           normal_x;
    coord_t           normal_y;
    coord_t           normal_z;
    logic [MAT_W-1:0] hit_material;
  } hit_rec_t;

  typedef struct packed {
    coord_t           center_x;
    coord_t           center_y;
    coord_t           center_z;
    logic [RADW-1:0]  sphere_radius;
    logic [MAT_W-1:0] material_id;
  } cfg_t;

  typedef struct packed {
    logic         miss;
    coord_t [2:0] org;
    coord_t [2:0] dir;
    coord_t       lo;
    coord_t       up;
  } ray_ctx_t;

  function automatic coord_t sat_coord(input logic signed [PW-1:0] v);
    coord_t r;
    if (v > PW'(COORD_MAX)) r = COORD_MAX;
    else if (v < PW'(COORD_MIN)) r = COORD_MIN;
    else r = coord_t'(v[COORD_WIDTH-1:0]);
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ray_sphere_intersect_top.sv -----
// ray_sphere_intersect_top: configuration registers, flow control and the
// intersection pipeline. Depends on rsi_pkg and rsi_datapath.
//
//  channel  signals                         payload
//  in       in_valid / in_ready             in_data  (rsi_pkg::ray_t)
//  out      out_valid / out_ready           out_data (rsi_pkg::hit_rec_t)
//  cfg      cfg_write                       cfg_index, cfg_data
//
// One ray per cycle while the output is not stalled. The depth
// is set by the square root (66 stages), the t division (32) and the normal
// division (31). Reset is synchronous and clears all valid bits and loads the
// register defaults. A stalled output freezes the whole pipeline; nothing is
// dropped or duplicated.
`default_nettype none
module ray_sphere_intersect_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rsi_pkg::ray_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rsi_pkg::hit_rec_t               out_data,
  input  logic                            cfg_write,
  input  logic [rsi_pkg::IDX_W-1:0]       cfg_index,
  input  logic [rsi_pkg::COORD_WIDTH-1:0] cfg_data
);
  import rsi_pkg::*;

  cfg_t cfg;
  logic ce;

  assign ce       = !out_valid || out_ready;
  assign in_ready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x      <= '0;
      cfg.center_y      <= '0;
      cfg.center_z      <= '0;
      cfg.sphere_radius <= RADIUS_RESET;
      cfg.material_id   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CENTER_X: cfg.center_x      <= cfg_data;
        REG_CENTER_Y: cfg.center_y      <= cfg_data;
        REG_CENTER_Z: cfg.center_z      <= cfg_data;
        REG_RADIUS:   cfg.sphere_radius <= cfg_data[RADW-1:0];
        REG_MATERIAL: cfg.material_id   <= cfg_data[MAT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rsi_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (in_valid),
    .ray       (in_data),
    .cfg       (cfg),
    .out_valid (out_valid),
    .result    (out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/core/rsi_datapath.sv -----
// rsi_datapath: fully pipelined quadratic solve, root select, hit point and
// normal. Depends on rsi_pkg; stalls by a common clock enable from the top.
`default_nettype none
module rsi_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  rsi_pkg::ray_t     ray,
  input  rsi_pkg::cfg_t     cfg,
  output logic              out_valid,
  output rsi_pkg::hit_rec_t result
);
  import rsi_pkg::*;

  coord_t [2:0] ctr;
  ray_ctx_t     ctx_in;

  assign ctr = {cfg.center_z, cfg.center_y, cfg.center_x};

  always_comb begin
    ctx_in.miss = 1'b0;
    ctx_in.org  = {ray.origin_z, ray.origin_y, ray.origin_x};
    ctx_in.dir  = {ray.dir_z, ray.dir_y, ray.dir_x};
    ctx_in.lo   = ray.t_lower;
    ctx_in.up   = ray.t_upper;
  end

  // ---- stage 1: oc = o - c
  logic                  s1_v;
  ray_ctx_t              s1_ctx;
  logic signed [OCW-1:0] s1_oc [3];

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (ce) s1_v <= in_valid;
    if (ce) begin
      s1_ctx <= ctx_in;
      for (int i = 0; i < 3; i++) s1_oc[i] <= OCW'(ctx_in.org[i]) - OCW'(ctr[i]);
    end
  end

  // ---- stage 2: component products
  logic                          s2_v;
  ray_ctx_t                      s2_ctx;
  logic signed [AW-1:0]          s2_dd [3];
  logic signed [OCW+COORD_WIDTH-1:0] s2_od [3];
  logic signed [2*OCW-1:0]       s2_oo [3];
  logic [2*RADW-1:0]             s2_rr;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (ce) s2_v <= s1_v;
    if (ce) begin
      s2_ctx <= s1_ctx;
      for (int i = 0; i < 3; i++) begin
        s2_dd[i] <= AW'(s1_ctx.dir[i]) * AW'(s1_ctx.dir[i]);
        s2_od[i] <= (OCW+COORD_WIDTH)'(s1_oc[i]) * (OCW+COORD_WIDTH)'(s1_ctx.dir[i]);
        s2_oo[i] <= (2*OCW)'(s1_oc[i]) * (2*OCW)'(s1_oc[i]);
      end
      s2_rr <= (2*RADW)'(cfg.sphere_radius) * (2*RADW)'(cfg.sphere_radius);
    end
  end

  // ---- stage 3: a, h, k
  logic                 s3_v;
  ray_ctx_t             s3_ctx;
  logic [AW-1:0]        s3_a;
  logic signed [HW-1:0] s3_h;
  logic signed [HW-1:0] s3_k;

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (ce) s3_v <= s2_v;
    if (ce) begin
      s3_ctx <= s2_ctx;
      s3_a   <= s2_dd[0] + s2_dd[1] + s2_dd[2];
      s3_h   <= HW'(s2_od[0]) + HW'(s2_od[1]) + HW'(s2_od[2]);
      s3_k   <= HW'(s2_oo[0]) + HW'(s2_oo[1]) + HW'(s2_oo[2]) - HW'(s2_rr);
    end
  end

  // ---- stage 4: partial products of h*h and a*k
  logic signed [HHW-1:0] h_hi, k_hi;
  logic [SPL-1:0]        h_lo, k_lo, a_lo;
  logic [AHW-1:0]        a_hi;

  assign h_hi = s3_h[HW-1:SPL];
  assign k_hi = s3_k[HW-1:SPL];
  assign h_lo = s3_h[SPL-1:0];
  assign k_lo = s3_k[SPL-1:0];
  assign a_lo = s3_a[SPL-1:0];
  assign a_hi = s3_a[AW-1:SPL];

  logic                         s4_v;
  ray_ctx_t                     s4_ctx;
  logic [AW-1:0]                s4_a;
  logic signed [HW-1:0]         s4_h;
  logic signed [2*HHW-1:0]      s4_hh;
  logic signed [HW:0]           s4_hx;
  logic [2*SPL-1:0]             s4_hl;
  logic signed [AHW+HHW:0]      s4_ahh;
  logic [AHW+SPL-1:0]           s4_ahl;
  logic signed [SPL+HHW:0]      s4_alh;
  logic [2*SPL-1:0]             s4_all;

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (ce) s4_v <= s3_v;
    if (ce) begin
      s4_ctx <= s3_ctx;
      s4_a   <= s3_a;
      s4_h   <= s3_h;
      s4_hh  <= (2*HHW)'(h_hi) * (2*HHW)'(h_hi);
      s4_hx  <= (HW+1)'(h_hi) * (HW+1)'($signed({1'b0, h_lo}));
      s4_hl  <= (2*SPL)'(h_lo) * (2*SPL)'(h_lo);
      s4_ahh <= (AHW+HHW+1)'($signed({1'b0, a_hi})) * (AHW+HHW+1)'(k_hi);
      s4_ahl <= (AHW+SPL)'(a_hi) * (AHW+SPL)'(k_lo);
      s4_alh <= (SPL+HHW+1)'($signed({1'b0, a_lo})) * (SPL+HHW+1)'(k_hi);
      s4_all <= (2*SPL)'(a_lo) * (2*SPL)'(k_lo);
    end
  end

  // ---- stage 5: h*h and a*k
  logic                  s5_v;
  ray_ctx_t              s5_ctx;
  logic [AW-1:0]         s5_a;
  logic signed [HW-1:0]  s5_h;
  logic signed [DSW-1:0] s5_h2;
  logic signed [DSW-1:0] s5_ak;

  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (ce) s5_v <= s4_v;
    if (ce) begin
      s5_ctx <= s4_ctx;
      s5_a   <= s4_a;
      s5_h   <= s4_h;
      s5_h2  <= (DSW'(s4_hh) <<< (2*SPL)) + (DSW'(s4_hx) <<< (SPL+1)) + DSW'(s4_hl);
      s5_ak  <= (DSW'(s4_ahh) <<< (2*SPL)) + (DSW'(s4_ahl) <<< SPL)
              + (DSW'(s4_alh) <<< SPL) + DSW'(s4_all);
    end
  end

  // ---- stage 6: discriminant, miss flag, then square root pipeline
  logic signed [DSW-1:0] disc;
  logic                  s6_miss;
  ray_ctx_t              s6_ctx;

  assign disc    = s5_h2 - s5_ak;
  assign s6_miss = (s5_a == '0) || (disc <= 0);

  always_comb begin
    s6_ctx      = s5_ctx;
    s6_ctx.miss = s6_miss;
  end

  logic                 sq_v   [SQ_STEPS+1];
  ray_ctx_t             sq_ctx [SQ_STEPS+1];
  logic [AW-1:0]        sq_a   [SQ_STEPS+1];
  logic signed [HW-1:0] sq_h   [SQ_STEPS+1];
  logic [DW-1:0]        sq_x   [SQ_STEPS+1];
  logic [DW-1:0]        sq_r   [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (ce) sq_v[0] <= s5_v;
    if (ce) begin
      sq_ctx[0] <= s6_ctx;
      sq_a[0]   <= s5_a;
      sq_h[0]   <= s5_h;
      sq_x[0]   <= s6_miss ? '0 : disc[DW-1:0];
      sq_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [DW-1:0] BIT = DW'(1) << (DW - 2 - 2*j);
    logic [DW-1:0] trial;
    assign trial = sq_r[j] + BIT;
    always_ff @(posedge clk) begin
      if (rst) sq_v[j+1] <= 1'b0;
      else if (ce) sq_v[j+1] <= sq_v[j];
      if (ce) begin
        sq_ctx[j+1] <= sq_ctx[j];
        sq_a[j+1]   <= sq_a[j];
        sq_h[j+1]   <= sq_h[j];
        if (sq_x[j] >= trial) begin
          sq_x[j+1] <= sq_x[j] - trial;
          sq_r[j+1] <= (sq_r[j] >> 1) + BIT;
        end else begin
          sq_x[j+1] <= sq_x[j];
          sq_r[j+1] <= sq_r[j] >> 1;
        end
      end
    end
  end

  // ---- numerators -h -/+ sqrt
  logic [SQW-1:0]       sq_root;
  logic                 nm_v;
  ray_ctx_t             nm_ctx;
  logic [AW-1:0]        nm_a;
  logic signed [NW-1:0] nm_n [2];

  assign sq_root = sq_r[SQ_STEPS][SQW-1:0];

  always_ff @(posedge clk) begin
    if (rst) nm_v <= 1'b0;
    else if (ce) nm_v <= sq_v[SQ_STEPS];
    if (ce) begin
      nm_ctx  <= sq_ctx[SQ_STEPS];
      nm_a    <= sq_a[SQ_STEPS];
      nm_n[0] <= -NW'(sq_h[SQ_STEPS]) - NW'($signed({1'b0, sq_root}));
      nm_n[1] <= -NW'(sq_h[SQ_STEPS]) + NW'($signed({1'b0, sq_root}));
    end
  end

  // ---- t = n*S / a for both roots, restoring, one quotient bit per stage
  logic signed [NW-1:0] n_abs [2];
  logic [TRW-1:0]       dvd   [2];
  logic [TRW-1:0]       a_top;

  assign a_top = TRW'(nm_a) << COORD_WIDTH;
  for (genvar k = 0; k < 2; k++) begin : g_dvd
    assign n_abs[k] = nm_n[k][NW-1] ? -nm_n[k] : nm_n[k];
    assign dvd[k]   = TRW'(n_abs[k][NW-2:0]) << FRAC_BITS;
  end

  logic                   dv_v   [COORD_WIDTH+1];
  ray_ctx_t               dv_ctx [COORD_WIDTH+1];
  logic [AW-1:0]          dv_a   [COORD_WIDTH+1];
  logic [1:0]             dv_neg [COORD_WIDTH+1];
  logic [1:0]             dv_ovf [COORD_WIDTH+1];
  logic [TRW-1:0]         dv_rem [COORD_WIDTH+1][2];
  logic [COORD_WIDTH-1:0] dv_q   [COORD_WIDTH+1][2];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (ce) dv_v[0] <= nm_v;
    if (ce) begin
      dv_ctx[0] <= nm_ctx;
      dv_a[0]   <= nm_a;
      for (int k = 0; k < 2; k++) begin
        dv_neg[0][k] <= nm_n[k][NW-1];
        dv_ovf[0][k] <= dvd[k] >= a_top;
        dv_rem[0][k] <= dvd[k];
        dv_q[0][k]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < COORD_WIDTH; j++) begin : g_tdiv
    localparam int SH = COORD_WIDTH - 1 - j;
    logic [TRW-1:0] trial;
    assign trial = TRW'(dv_a[j]) << SH;
    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else if (ce) dv_v[j+1] <= dv_v[j];
      if (ce) begin
        dv_ctx[j+1] <= dv_ctx[j];
        dv_a[j+1]   <= dv_a[j];
        dv_neg[j+1] <= dv_neg[j];
        dv_ovf[j+1] <= dv_ovf[j];
        for (int k = 0; k < 2; k++) begin
          if (dv_rem[j][k] >= trial) begin
            dv_rem[j+1][k] <= dv_rem[j][k] - trial;
            dv_q[j+1][k]   <= dv_q[j][k] | (COORD_WIDTH'(1) << SH);
          end else begin
            dv_rem[j+1][k] <= dv_rem[j][k];
            dv_q[j+1][k]   <= dv_q[j][k];
          end
        end
      end
    end
  end

  // ---- root select: nearer root first, strict bounds
  logic signed [TW-1:0] t_val [2];
  logic [1:0]           found;

  for (genvar k = 0; k < 2; k++) begin : g_found
    assign t_val[k] = dv_neg[COORD_WIDTH][k] ? -$signed({1'b0, dv_q[COORD_WIDTH][k]})
                                             : $signed({1'b0, dv_q[COORD_WIDTH][k]});
    assign found[k] = !dv_ovf[COORD_WIDTH][k]
                   && (t_val[k] > TW'(dv_ctx[COORD_WIDTH].lo))
                   && (t_val[k] < TW'(dv_ctx[COORD_WIDTH].up));
  end

  logic     sel_v;
  logic     sel_hit;
  coord_t   sel_t;
  ray_ctx_t sel_ctx;

  always_ff @(posedge clk) begin
    if (rst) sel_v <= 1'b0;
    else if (ce) sel_v <= dv_v[COORD_WIDTH];
    if (ce) begin
      sel_ctx <= dv_ctx[COORD_WIDTH];
      sel_hit <= !dv_ctx[COORD_WIDTH].miss && (found[0] || found[1]);
      sel_t   <= found[0] ? coord_t'(t_val[0][COORD_WIDTH-1:0])
                          : coord_t'(t_val[1][COORD_WIDTH-1:0]);
    end
  end

  // ---- t*d
  logic                            pm_v;
  logic                            pm_hit;
  coord_t                          pm_t;
  coord_t [2:0]                    pm_org;
  logic signed [2*COORD_WIDTH-1:0] pm_prod [3];

  always_ff @(posedge clk) begin
    if (rst) pm_v <= 1'b0;
    else if (ce) pm_v <= sel_v;
    if (ce) begin
      pm_hit <= sel_hit;
      pm_t   <= sel_t;
      pm_org <= sel_ctx.org;
      for (int i = 0; i < 3; i++)
        pm_prod[i] <= (2*COORD_WIDTH)'(sel_t) * (2*COORD_WIDTH)'(sel_ctx.dir[i]);
    end
  end

  // ---- p = o + floor(t*d / S), saturated
  logic         pt_v;
  logic         pt_hit;
  coord_t       pt_t;
  coord_t [2:0] pt_p;

  always_ff @(posedge clk) begin
    if (rst) pt_v <= 1'b0;
    else if (ce) pt_v <= pm_v;
    if (ce) begin
      pt_hit <= pm_hit;
      pt_t   <= pm_t;
      for (int i = 0; i < 3; i++)
        pt_p[i] <= sat_coord(PW'(pm_org[i]) + PW'(pm_prod[i] >>> FRAC_BITS));
    end
  end

  // ---- n = (p - c)*S / R, one quotient bit per stage
  logic signed [TW-1:0] pc     [3];
  logic signed [TW-1:0] pc_abs [3];
  logic [NRW-1:0]       ndvd   [3];
  logic [NRW-1:0]       r_top;

  assign r_top = NRW'(cfg.sphere_radius) << (COORD_WIDTH - 1);
  for (genvar i = 0; i < 3; i++) begin : g_pc
    assign pc[i]     = TW'(pt_p[i]) - TW'(ctr[i]);
    assign pc_abs[i] = pc[i][TW-1] ? -pc[i] : pc[i];
    assign ndvd[i]   = NRW'(pc_abs[i][COORD_WIDTH-1:0]) << FRAC_BITS;
  end

  logic                   nd_v   [COORD_WIDTH];
  logic                   nd_hit [COORD_WIDTH];
  coord_t                 nd_t   [COORD_WIDTH];
  coord_t [2:0]           nd_p   [COORD_WIDTH];
  logic [2:0]             nd_neg [COORD_WIDTH];
  logic [2:0]             nd_ovf [COORD_WIDTH];
  logic [NRW-1:0]         nd_rem [COORD_WIDTH][3];
  logic [COORD_WIDTH-2:0] nd_q   [COORD_WIDTH][3];

  always_ff @(posedge clk) begin
    if (rst) nd_v[0] <= 1'b0;
    else if (ce) nd_v[0] <= pt_v;
    if (ce) begin
      nd_hit[0] <= pt_hit;
      nd_t[0]   <= pt_t;
      nd_p[0]   <= pt_p;
      for (int i = 0; i < 3; i++) begin
        nd_neg[0][i] <= pc[i][TW-1];
        nd_ovf[0][i] <= ndvd[i] >= r_top;
        nd_rem[0][i] <= ndvd[i];
        nd_q[0][i]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < COORD_WIDTH - 1; j++) begin : g_ndiv
    localparam int SH = COORD_WIDTH - 2 - j;
    logic [NRW-1:0] trial;
    assign trial = NRW'(cfg.sphere_radius) << SH;
    always_ff @(posedge clk) begin
      if (rst) nd_v[j+1] <= 1'b0;
      else if (ce) nd_v[j+1] <= nd_v[j];
      if (ce) begin
        nd_hit[j+1] <= nd_hit[j];
        nd_t[j+1]   <= nd_t[j];
        nd_p[j+1]   <= nd_p[j];
        nd_neg[j+1] <= nd_neg[j];
        nd_ovf[j+1] <= nd_ovf[j];
        for (int i = 0; i < 3; i++) begin
          if (nd_rem[j][i] >= trial) begin
            nd_rem[j+1][i] <= nd_rem[j][i] - trial;
            nd_q[j+1][i]   <= nd_q[j][i] | ((COORD_WIDTH-1)'(1) << SH);
          end else begin
            nd_rem[j+1][i] <= nd_rem[j][i];
            nd_q[j+1][i]   <= nd_q[j][i];
          end
        end
      end
    end
  end

  // ---- output register
  localparam int NL = COORD_WIDTH - 1;

  coord_t [2:0] nrm;
  for (genvar i = 0; i < 3; i++) begin : g_nrm
    coord_t qv;
    assign qv = coord_t'({1'b0, nd_q[NL][i]});
    assign nrm[i] = nd_ovf[NL][i] ? (nd_neg[NL][i] ? COORD_MIN : COORD_MAX)
                                  : (nd_neg[NL][i] ? -qv : qv);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ce) out_valid <= nd_v[NL];
    if (ce) begin
      if (nd_hit[NL]) begin
        result.hit          <= 1'b1;
        result.hit_t        <= nd_t[NL];
        result.point_x      <= nd_p[NL][0];
        result.point_y      <= nd_p[NL][1];
        result.point_z      <= nd_p[NL][2];
        result.normal_x     <= nrm[0];
        result.normal_y     <= nrm[1];
        result.normal_z     <= nrm[2];
        result.hit_material <= cfg.material_id;
      end else begin
        result <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rsi_checker.sv -----
// rsi_checker: port-level checks on the intersector top, bound below.
// Depends on rsi_pkg.
`default_nettype none
module rsi_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input rsi_pkg::hit_rec_t out_data
);
  import rsi_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input back-pressured without an output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result transaction changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.hit) |-> (out_data.hit_t == '0 && out_data.point_x == '0
      && out_data.point_y == '0 && out_data.point_z == '0 && out_data.normal_x == '0
      && out_data.normal_y == '0 && out_data.normal_z == '0
      && out_data.hit_material == '0))
    else $error("miss carries nonzero fields");

endmodule

bind ray_sphere_intersect_top rsi_checker u_rsi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
